@@ src/has_pkg.sv @@
// Package for the Hungarian assignment solver: widths, sizes and the slack marker.
// No dependencies.
`default_nettype none
package has_pkg;
  localparam int unsigned MAX_SIZE = 16;
  localparam int unsigned COST_W  = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned POT_W   = 32;
  localparam logic signed [POT_W-1:0] SLACK_INF = 32'sd2147483647;
endpackage
`default_nettype wire

@@ src/has_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module has_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/hungarian_assignment_solver.sv @@
// Top level of the Hungarian assignment solver; uses has_pkg and has_ram.
// Cost matrix in one RAM; potentials, matches, slack and links in small registers.
//
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_row, in_col, in_cost, in_solve_req
// out     | output    | out_valid, out_ready, out_assigned_row/col, out_pair_cost, ...
// cfg     | input     | cfg_we, cfg_data (matrix_size)
//
// A plain write item is taken while idle. A solve item holds in_ready low for the
// whole solve and its results: a clear state, then per row a setup state, per
// augmentation step a scan over the columns (one RAM read per column) and an update
// state, and an augment state that walks the path links and then augments. Each
// result then passes ST_ORD (RAM read), ST_ORDW (output register) and ST_EMIT, where
// it waits for out_ready. Reset is synchronous; the cost RAM is not cleared.
`default_nettype none
module hungarian_assignment_solver (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [has_pkg::IDX_W-1:0]   in_row,
  input  wire logic [has_pkg::IDX_W-1:0]   in_col,
  input  wire logic [has_pkg::COST_W-1:0]  in_cost,
  input  wire logic                        in_solve_req,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [has_pkg::IDX_W-1:0]        out_assigned_row,
  output logic [has_pkg::IDX_W-1:0]        out_assigned_col,
  output logic [has_pkg::COST_W-1:0]       out_pair_cost,
  output logic [has_pkg::TOTAL_W-1:0]      out_total_cost,
  output logic                             out_last,
  input  wire logic                        cfg_we,
  input  wire logic [has_pkg::SIZE_W-1:0]  cfg_data
);
  import has_pkg::*;

  localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int unsigned RAW = 2 * AW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_INIT  = 9'b000000010,
    ST_ROW   = 9'b000000100,
    ST_SCAN  = 9'b000001000,
    ST_UPD   = 9'b000010000,
    ST_AUG   = 9'b000100000,
    ST_ORD   = 9'b001000000,
    ST_ORDW  = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] msize_r;
  logic [CW-1:0] n_r;

  logic signed [POT_W-1:0] u_r [MAX_SIZE];
  logic signed [POT_W-1:0] v_r [MAX_SIZE];
  logic signed [POT_W-1:0] slack_r [MAX_SIZE];
  logic [AW:0] match_r [MAX_SIZE];
  logic [AW:0] link_r [MAX_SIZE];
  logic [MAX_SIZE-1:0] vis_r;

  logic [CW-1:0] i_r, c_r, k_r;
  logic [AW:0] cur_r, prev_r, pick_r;
  logic signed [POT_W-1:0] pmin_r;
  logic [CW-1:0] rc_r;
  logic rv_r;
  logic [TOTAL_W-1:0] total_r;

  logic [AW-1:0] ram_wr, ram_wc, ram_rr, ram_rc;
  logic ram_we;
  logic [COST_W-1:0] ram_rd;

  logic [IDX_W-1:0] o_row_r, o_col_r;
  logic [COST_W-1:0] o_cost_r;
  logic o_last_r, o_valid_r;

  always_comb begin
    if (msize_r == '0) n_r = CW'(1);
    else if (32'(msize_r) > MAX_SIZE) n_r = CW'(MAX_SIZE);
    else n_r = CW'(msize_r);
  end

  assign ram_we = in_valid && in_ready && (32'(in_row) < MAX_SIZE)
                  && (32'(in_col) < MAX_SIZE);
  assign ram_wr = AW'(in_row);
  assign ram_wc = AW'(in_col);

  always_comb begin
    ram_rr = cur_r[AW-1:0];
    ram_rc = c_r[AW-1:0];
    if (state_r == ST_ORD || state_r == ST_ORDW || state_r == ST_EMIT) begin
      ram_rr = match_r[k_r[AW-1:0]][AW-1:0];
      ram_rc = k_r[AW-1:0];
    end
  end

  has_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (RAW'({ram_wr, ram_wc})),
    .wdata (in_cost),
    .raddr (RAW'({ram_rr, ram_rc})),
    .rdata (ram_rd)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = o_valid_r;
  assign out_assigned_row = o_row_r;
  assign out_assigned_col = o_col_r;
  assign out_pair_cost = o_cost_r;
  assign out_total_cost = total_r;
  assign out_last = o_last_r;

  logic signed [POT_W-1:0] red;
  logic signed [POT_W-1:0] sl_new;
  logic [AW-1:0] ca;
  assign ca = rc_r[AW-1:0];
  always_comb begin
    red = POT_W'(ram_rd) - u_r[cur_r[AW-1:0]] - v_r[ca];
    sl_new = (red < slack_r[ca]) ? red : slack_r[ca];
  end

  function automatic logic signed [POT_W-1:0] fixsum(input int r);
    logic hit;
    hit = 1'b0;
    for (int j = 0; j < MAX_SIZE; j++) begin
      if (32'(j) < 32'(n_r) && vis_r[j] && match_r[j] == (AW+1)'(r)) hit = 1'b1;
    end
    return hit ? pmin_r : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      msize_r <= SIZE_W'(MAX_SIZE);
      o_valid_r <= 1'b0;
    end else begin
      if (cfg_we) msize_r <= cfg_data;
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_solve_req) state_r <= ST_INIT;
        end
        ST_INIT: begin
          for (int j = 0; j < MAX_SIZE; j++) begin
            u_r[j] <= '0;
            v_r[j] <= '0;
            match_r[j] <= '1;
          end
          i_r <= '0;
          state_r <= ST_ROW;
        end
        ST_ROW: begin
          if (i_r == n_r) begin
            k_r <= '0;
            total_r <= '0;
            state_r <= ST_ORD;
          end else begin
            for (int j = 0; j < MAX_SIZE; j++) begin
              slack_r[j] <= SLACK_INF;
              link_r[j] <= '1;
            end
            vis_r <= '0;
            cur_r <= (AW+1)'(i_r);
            prev_r <= '1;
            c_r <= '0;
            rv_r <= 1'b0;
            pick_r <= '1;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rv_r <= (c_r < n_r);
          rc_r <= c_r;
          if (c_r < n_r) c_r <= c_r + CW'(1);
          if (rv_r && !vis_r[ca]) begin
            if (red < slack_r[ca]) begin
              slack_r[ca] <= red;
              link_r[ca] <= prev_r;
            end
            if ((pick_r == '1) || (sl_new < pmin_r)) begin
              pick_r <= (AW+1)'(rc_r);
              pmin_r <= sl_new;
            end
          end
          if (rv_r && rc_r == n_r - CW'(1)) begin
            state_r <= ST_UPD;
            c_r <= '0;
          end
        end
        ST_UPD: begin
          if (pick_r == '1) begin
            i_r <= i_r + CW'(1);
            state_r <= ST_ROW;
          end else begin
            for (int j = 0; j < MAX_SIZE; j++) begin
              if (32'(j) < 32'(n_r)) begin
                if (vis_r[j]) begin
                  v_r[j] <= v_r[j] - pmin_r;
                end else begin
                  slack_r[j] <= slack_r[j] - pmin_r;
                end
              end
            end
            for (int r = 0; r < MAX_SIZE; r++) begin
              if (32'(r) == 32'(i_r)) u_r[r] <= u_r[r] + pmin_r + (fixsum(r));
              else u_r[r] <= u_r[r] + fixsum(r);
            end
            vis_r[pick_r[AW-1:0]] <= 1'b1;
            prev_r <= pick_r;
            cur_r <= match_r[pick_r[AW-1:0]];
            if (match_r[pick_r[AW-1:0]] == '1) begin
              c_r <= CW'(pick_r);
              state_r <= ST_AUG;
            end else begin
              c_r <= '0;
              rv_r <= 1'b0;
              pick_r <= '1;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_AUG: begin
          if (link_r[c_r[AW-1:0]] != '1) begin
            match_r[c_r[AW-1:0]] <= match_r[link_r[c_r[AW-1:0]][AW-1:0]];
            c_r <= CW'(link_r[c_r[AW-1:0]]);
          end else begin
            match_r[c_r[AW-1:0]] <= (AW+1)'(i_r);
            i_r <= i_r + CW'(1);
            state_r <= ST_ROW;
          end
        end
        ST_ORD: begin
          state_r <= ST_ORDW;
        end
        ST_ORDW: begin
          o_valid_r <= 1'b1;
          o_row_r <= IDX_W'(match_r[k_r[AW-1:0]][AW-1:0]);
          o_col_r <= IDX_W'(k_r);
          o_cost_r <= ram_rd;
          total_r <= total_r + TOTAL_W'(ram_rd);
          o_last_r <= (k_r == n_r - CW'(1));
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_ready) begin
            o_valid_r <= 1'b0;
            if (k_r == n_r - CW'(1)) state_r <= ST_IDLE;
            else begin
              k_r <= k_r + CW'(1);
              state_r <= ST_ORD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/has_checker.sv @@
// Checker for the Hungarian assignment solver: watches the input, result and
// configuration ports, predicts each assignment and compares every result item.
// Depends on has_pkg.
module has_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [has_pkg::IDX_W-1:0]  in_row,
  input  logic [has_pkg::IDX_W-1:0]  in_col,
  input  logic [has_pkg::COST_W-1:0] in_cost,
  input  logic                       in_solve_req,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [has_pkg::IDX_W-1:0]  out_assigned_row,
  input  logic [has_pkg::IDX_W-1:0]  out_assigned_col,
  input  logic [has_pkg::COST_W-1:0] out_pair_cost,
  input  logic [has_pkg::TOTAL_W-1:0] out_total_cost,
  input  logic                       out_last,
  input  logic                       cfg_we,
  input  logic [has_pkg::SIZE_W-1:0] cfg_data,
  output int                         fails,
  output int                         pending
);
  localparam int DIM = 16;
  localparam longint INF = 64'sd2147483647;
  localparam int NONE = -1;

  typedef struct packed {
    logic [has_pkg::IDX_W-1:0]   arow;
    logic [has_pkg::IDX_W-1:0]   acol;
    logic [has_pkg::COST_W-1:0]  pcost;
    logic [has_pkg::TOTAL_W-1:0] total;
    logic                        last;
  } pair_t;

  logic [has_pkg::COST_W-1:0] cost_tbl [DIM*DIM];
  logic [has_pkg::SIZE_W-1:0] size_reg;
  longint row_pot [DIM];
  longint col_pot [DIM];
  longint slack [DIM];
  int     match_row [DIM];
  int     link [DIM];
  bit     seen [DIM];
  pair_t  assign_q [$];

  assign pending = assign_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t: result mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic void find_assignment(input int n);
    int cur, prv, pick, r, b, guard, c;
    longint red, delta;
    for (int k = 0; k < DIM; k++) begin
      row_pot[k] = 0;
      col_pot[k] = 0;
      match_row[k] = NONE;
    end
    for (int i = 0; i < n; i++) begin
      cur = i;
      prv = NONE;
      pick = NONE;
      for (int k = 0; k < DIM; k++) begin
        slack[k] = INF;
        link[k] = NONE;
        seen[k] = 0;
      end
      while (cur != NONE) begin
        pick = NONE;
        for (int k = 0; k < n; k++) begin
          if (!seen[k]) begin
            red = longint'(cost_tbl[cur*DIM+k]) - row_pot[cur] - col_pot[k];
            if (red < slack[k]) begin
              slack[k] = red;
              link[k] = prv;
            end
            if (pick == NONE || slack[k] < slack[pick]) pick = k;
          end
        end
        if (pick == NONE) break;
        delta = slack[pick];
        for (int k = 0; k < n; k++) begin
          if (seen[k]) begin
            r = match_row[k];
            if (r >= 0 && r < DIM) row_pot[r] += delta;
            col_pot[k] -= delta;
          end else begin
            slack[k] -= delta;
          end
        end
        row_pot[i] += delta;
        seen[pick] = 1;
        prv = pick;
        cur = match_row[pick];
      end
      if (pick == NONE) continue;
      guard = 0;
      c = pick;
      while (link[c] != NONE && guard < DIM) begin
        b = link[c];
        match_row[c] = match_row[b];
        c = b;
        guard++;
      end
      match_row[c] = i;
    end
  endfunction

  function automatic void predict_solve();
    int n, mr;
    logic [has_pkg::COST_W-1:0] pc;
    logic [has_pkg::TOTAL_W-1:0] sum;
    pair_t p;
    n = int'(size_reg);
    if (n < 1) n = 1;
    if (n > DIM) n = DIM;
    find_assignment(n);
    sum = '0;
    for (int k = 0; k < n; k++) begin
      mr = match_row[k];
      pc = '0;
      if (mr < 0 || mr >= DIM) mr = 0;
      else pc = cost_tbl[mr*DIM+k];
      sum += pc;
      p.arow = mr[has_pkg::IDX_W-1:0];
      p.acol = k[has_pkg::IDX_W-1:0];
      p.pcost = pc;
      p.total = sum;
      p.last = (k == n - 1);
      assign_q = {assign_q, p};
    end
  endfunction

  initial fails = 0;

  always @(posedge clk) begin
    pair_t w;
    if (!rst_n) begin
      size_reg <= 5'd16;
      assign_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (assign_q.size() == 0) begin
          $display("%0t: result item with nothing expected", $realtime);
          fails++;
        end else begin
          w = assign_q.pop_front();
          if (out_assigned_row !== w.arow) report("assigned_row", out_assigned_row, w.arow);
          if (out_assigned_col !== w.acol) report("assigned_col", out_assigned_col, w.acol);
          if (out_pair_cost !== w.pcost) report("pair_cost", out_pair_cost, w.pcost);
          if (out_total_cost !== w.total) report("total_cost", out_total_cost, w.total);
          if (out_last !== w.last) report("last", out_last, w.last);
        end
      end
      if (in_valid && in_ready) begin
        cost_tbl[int'(in_row)*DIM + int'(in_col)] = in_cost;
        if (in_solve_req) predict_solve();
      end
      if (cfg_we) size_reg <= cfg_data;
    end
  end
endmodule

@@ tb/tb_hungarian_assignment_solver.sv @@
// Testbench top for the Hungarian assignment solver: drives cost entries, solve
// requests and size settings with random gaps and stalls, and gives the verdict.
// Depends on has_pkg, hungarian_assignment_solver and has_checker.
module tb_hungarian_assignment_solver;
  localparam int DIM = 16;
  localparam int WATCH_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [has_pkg::IDX_W-1:0] in_row;
  logic [has_pkg::IDX_W-1:0] in_col;
  logic [has_pkg::COST_W-1:0] in_cost;
  logic in_solve_req;
  logic out_valid;
  logic out_ready;
  logic [has_pkg::IDX_W-1:0] out_assigned_row;
  logic [has_pkg::IDX_W-1:0] out_assigned_col;
  logic [has_pkg::COST_W-1:0] out_pair_cost;
  logic [has_pkg::TOTAL_W-1:0] out_total_cost;
  logic out_last;
  logic cfg_we;
  logic [has_pkg::SIZE_W-1:0] cfg_data;
  int fails;
  int pending;
  int idle_cycles;
  bit hold_out;
  bit [DIM*DIM-1:0] written;
  int items_sent;

  hungarian_assignment_solver u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_row(in_row), .in_col(in_col),
    .in_cost(in_cost), .in_solve_req(in_solve_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_assigned_row(out_assigned_row), .out_assigned_col(out_assigned_col),
    .out_pair_cost(out_pair_cost), .out_total_cost(out_total_cost), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  has_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_row(in_row), .in_col(in_col),
    .in_cost(in_cost), .in_solve_req(in_solve_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_assigned_row(out_assigned_row), .out_assigned_col(out_assigned_col),
    .out_pair_cost(out_pair_cost), .out_total_cost(out_total_cost), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_cost();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 2) return 16'($urandom_range(0, 3));
    if (sel == 2) return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    return 16'($urandom());
  endfunction

  function automatic bit block_written(input int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!written[r*DIM+c]) return 0;
      end
    end
    return 1;
  endfunction

  initial begin
    out_ready = 0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_out = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input int r, input int c, input logic [15:0] v, input bit s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_row <= r[3:0];
    in_col <= c[3:0];
    in_cost <= v;
    in_solve_req <= s;
    do @(posedge clk); while (!in_ready);
    written[r*DIM+c] = 1;
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(input logic [4:0] val);
    cfg_we <= 1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Fill the n by n block in shuffled order; the last entry carries the solve.
  task automatic fill_and_solve(input int n, input bit flat);
    int order[$];
    int idx;
    for (int k = 0; k < n*n; k++) order = {order, k};
    order.shuffle();
    for (int k = 0; k < n*n; k++) begin
      idx = order[k];
      send(idx / n, idx % n, flat ? 16'd7 : pick_cost(), k == n*n - 1);
    end
  endtask

  task automatic touch_and_solve(input int n);
    send($urandom_range(0, n-1), $urandom_range(0, n-1), pick_cost(), 1);
  endtask

  initial begin
    int n;
    logic [4:0] cv;
    rst_n = 0;
    in_valid = 0;
    in_row = 0;
    in_col = 0;
    in_cost = 0;
    in_solve_req = 0;
    cfg_we = 0;
    cfg_data = 0;
    hold_out = 0;
    written = '0;
    items_sent = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_size(5'd0);
    send(0, 0, 16'hffff, 1);
    send(0, 0, 16'h0000, 1);
    drain();
    set_size(5'd2);
    send(0, 0, 16'hffff, 0);
    send(0, 1, 16'hffff, 0);
    send(1, 0, 16'hffff, 0);
    send(1, 1, 16'hffff, 1);
    send(1, 1, 16'h0000, 1);
    send(0, 0, 16'h0000, 1);
    drain();
    set_size(5'd3);
    fill_and_solve(3, 1);
    send(2, 2, 16'h0001, 1);
    drain();

    set_size(5'd16);
    fill_and_solve(16, 0);
    drain();
    set_size(5'd31);
    touch_and_solve(16);
    send(15, 15, 16'hffff, 1);
    drain();

    set_size(5'd4);
    fill_and_solve(4, 0);
    drain();
    hold_out = 1;
    for (int k = 0; k < 6; k++) touch_and_solve(4);
    drain();

    items_sent = 0;
    while (items_sent < 150) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
      cv = (n == 1 && $urandom_range(0, 1) != 0) ? 5'd0 : n[4:0];
      set_size(cv);
      if (!block_written(n) || $urandom_range(0, 2) != 0) begin
        fill_and_solve(n, 0);
      end
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 3) == 0)
          send($urandom_range(0, 15), $urandom_range(0, 15), pick_cost(), 0);
        else
          touch_and_solve(n);
      end
      drain();
    end

    if (fails == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
